FILE: hw/rtl/jet_pkg.sv
// ----------------------------------------------------------------------------
// jet_pkg
// Shared types, constants and helpers for the Julia escape-time pixel unit.
// ----------------------------------------------------------------------------
`default_nettype none

package jet_pkg;

    // Field and arithmetic widths
    localparam int PIX_W    = 10;
    localparam int SCALE_W  = 31;
    localparam int FX_W     = 32;              // Q8.24 word
    localparam int FRAC_W   = 24;
    localparam int CNT_W    = 10;
    localparam int PROD_W   = 2 * FX_W;        // full product
    localparam int FLOOR_W  = PROD_W - FRAC_W; // product after floor shift
    localparam int SUM_W    = 44;              // headroom for 3*a - b + c
    localparam int IDX_W    = 3;

    // 4.0 in Q8.24, escape radius squared
    localparam logic signed [SUM_W-1:0] ESCAPE_LIMIT = SUM_W'(4) <<< FRAC_W;

    // Register reset values
    localparam logic [SCALE_W-1:0]       PIXEL_SCALE_RST = SCALE_W'(109052);
    localparam logic signed [FX_W-1:0]   OFFSET_REAL_RST = 32'sd33554432;
    localparam logic signed [FX_W-1:0]   OFFSET_IMAG_RST = 32'sd33554432;
    localparam logic signed [FX_W-1:0]   C_REAL_RST      = -32'sd27962;
    localparam logic signed [FX_W-1:0]   C_IMAG_RST      = 32'sd27962;
    localparam logic [CNT_W-1:0]         MAX_ITER_RST    = CNT_W'(50);

    // Register map
    typedef enum logic [IDX_W-1:0] {
        REG_PIXEL_SCALE = 3'd0,
        REG_OFFSET_REAL = 3'd1,
        REG_OFFSET_IMAG = 3'd2,
        REG_C_REAL      = 3'd3,
        REG_C_IMAG      = 3'd4,
        REG_MAX_ITER    = 3'd5,
        REG_CUBIC_MODE  = 3'd6
    } reg_idx_t;

    // Register file contents
    typedef struct packed {
        logic [SCALE_W-1:0]     pixel_scale;
        logic signed [FX_W-1:0] offset_real;
        logic signed [FX_W-1:0] offset_imag;
        logic signed [FX_W-1:0] c_real;
        logic signed [FX_W-1:0] c_imag;
        logic [CNT_W-1:0]       max_iterations;
        logic                   cubic_mode;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load_pixel;   // capture pixel, clear count
        logic init_z;       // map pixel to start point
        logic mul_sq;       // form x*x, y*y, x*y
        logic save_s;       // saturate squares for the cubic pass
        logic mul_cu;       // form sx*x, sy*x, sx*y, sy*y
        logic upd_sq;       // quadratic z update
        logic upd_cu;       // cubic z update
        logic out_load;     // load result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic stop;         // escaped or limit reached
        logic cubic;
    } status_t;

    // Clamp a wide signed sum to the Q8.24 word
    function automatic logic signed [FX_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic all_one;
        logic all_zero;
        begin
            all_one  = &v[SUM_W-1:FX_W-1];
            all_zero = ~|v[SUM_W-1:FX_W-1];
            if (all_one || all_zero)
                sat32 = v[FX_W-1:0];
            else if (v[SUM_W-1])
                sat32 = {1'b1, {(FX_W-1){1'b0}}};
            else
                sat32 = {1'b0, {(FX_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/jet_cfg_regs.sv
// ----------------------------------------------------------------------------
// jet_cfg_regs
// Configuration register file, written through a valid/ready write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module jet_cfg_regs
    import jet_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [FX_W-1:0]  cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Register writes; bits beyond a register's width are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_scale    <= PIXEL_SCALE_RST;
            cfg_reg.offset_real    <= OFFSET_REAL_RST;
            cfg_reg.offset_imag    <= OFFSET_IMAG_RST;
            cfg_reg.c_real         <= C_REAL_RST;
            cfg_reg.c_imag         <= C_IMAG_RST;
            cfg_reg.max_iterations <= MAX_ITER_RST;
            cfg_reg.cubic_mode     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_PIXEL_SCALE: cfg_reg.pixel_scale    <= cfg_data[SCALE_W-1:0];
                REG_OFFSET_REAL: cfg_reg.offset_real    <= cfg_data;
                REG_OFFSET_IMAG: cfg_reg.offset_imag    <= cfg_data;
                REG_C_REAL:      cfg_reg.c_real         <= cfg_data;
                REG_C_IMAG:      cfg_reg.c_imag         <= cfg_data;
                REG_MAX_ITER:    cfg_reg.max_iterations <= cfg_data[CNT_W-1:0];
                REG_CUBIC_MODE:  cfg_reg.cubic_mode     <= cfg_data[0];
                default:         ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/jet_datapath.sv
// ----------------------------------------------------------------------------
// jet_datapath
// Q8.24 datapath: start point mapping, a bank of four 32x32 multipliers with
// registered products, escape test, z update and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module jet_datapath
    import jet_pkg::*;
(
    input  wire logic             clk,
    input  wire cfg_t             cfg,
    input  wire cmd_t             cmd,
    output status_t               status,
    input  wire logic [PIX_W-1:0] pixel_x,
    input  wire logic [PIX_W-1:0] pixel_y,
    output logic [CNT_W-1:0]      iteration_count,
    output logic signed [FX_W-1:0] final_real,
    output logic signed [FX_W-1:0] final_imag
);

    logic [PIX_W-1:0]         px_reg;
    logic [PIX_W-1:0]         py_reg;
    logic [CNT_W-1:0]         count_reg;
    logic signed [FX_W-1:0]   x_reg;
    logic signed [FX_W-1:0]   y_reg;
    logic signed [FX_W-1:0]   sx_reg;
    logic signed [FX_W-1:0]   sy_reg;
    logic signed [PROD_W-1:0] p0_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic signed [PROD_W-1:0] p2_reg;
    logic signed [PROD_W-1:0] p3_reg;
    logic [CNT_W-1:0]         cnt_out_reg;
    logic signed [FX_W-1:0]   re_out_reg;
    logic signed [FX_W-1:0]   im_out_reg;

    logic [PIX_W+SCALE_W-1:0] scaled_x;
    logic [PIX_W+SCALE_W-1:0] scaled_y;
    logic signed [SUM_W-1:0]  start_x;
    logic signed [SUM_W-1:0]  start_y;
    logic signed [FX_W-1:0]   ma0, mb0, ma1, mb1, ma2;
    logic signed [PROD_W-1:0] m0, m1, m2, m3;
    logic signed [FLOOR_W-1:0] f0, f1, f2, f3;
    logic signed [SUM_W-1:0]  e0, e1, e2, e3;
    logic signed [SUM_W-1:0]  mag;
    logic signed [SUM_W-1:0]  c_re;
    logic signed [SUM_W-1:0]  c_im;
    logic signed [SUM_W-1:0]  nx_sq, ny_sq, nx_cu, ny_cu;

    // Start point: pixel * scale - offset
    assign scaled_x = (PIX_W+SCALE_W)'(px_reg) * (PIX_W+SCALE_W)'(cfg.pixel_scale);
    assign scaled_y = (PIX_W+SCALE_W)'(py_reg) * (PIX_W+SCALE_W)'(cfg.pixel_scale);
    assign start_x  = signed'(SUM_W'(scaled_x)) - SUM_W'(cfg.offset_real);
    assign start_y  = signed'(SUM_W'(scaled_y)) - SUM_W'(cfg.offset_imag);

    // Multiplier operand select: squares pass or cubic pass
    assign ma0 = cmd.mul_cu ? sx_reg : x_reg;
    assign mb0 = x_reg;
    assign ma1 = cmd.mul_cu ? sy_reg : y_reg;
    assign mb1 = cmd.mul_cu ? x_reg  : y_reg;
    assign ma2 = cmd.mul_cu ? sx_reg : x_reg;

    assign m0 = ma0 * mb0;
    assign m1 = ma1 * mb1;
    assign m2 = ma2 * y_reg;
    assign m3 = sy_reg * y_reg;

    // Floor by arithmetic shift of the registered products
    assign f0 = p0_reg[PROD_W-1:FRAC_W];
    assign f1 = p1_reg[PROD_W-1:FRAC_W];
    assign f2 = p2_reg[PROD_W-1:FRAC_W];
    assign f3 = p3_reg[PROD_W-1:FRAC_W];
    assign e0 = SUM_W'(f0);
    assign e1 = SUM_W'(f1);
    assign e2 = SUM_W'(f2);
    assign e3 = SUM_W'(f3);
    assign c_re = SUM_W'(cfg.c_real);
    assign c_im = SUM_W'(cfg.c_imag);

    // Escape test on the squares pass
    assign mag = e0 + e1;
    assign status.stop  = (mag > ESCAPE_LIMIT) || (count_reg >= cfg.max_iterations);
    assign status.cubic = cfg.cubic_mode;

    // Next z: quadratic from squares, cubic from the second pass
    assign nx_sq = e0 - e1 + c_re;
    assign ny_sq = (e2 <<< 1) + c_im;
    assign nx_cu = e0 - ((e1 <<< 1) + e1) + c_re;
    assign ny_cu = ((e2 <<< 1) + e2) - e3 + c_im;

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            px_reg    <= pixel_x;
            py_reg    <= pixel_y;
            count_reg <= '0;
        end
        if (cmd.init_z)
        begin
            x_reg <= sat32(start_x);
            y_reg <= sat32(start_y);
        end
        if (cmd.mul_sq || cmd.mul_cu)
        begin
            p0_reg <= m0;
            p1_reg <= m1;
            p2_reg <= m2;
        end
        if (cmd.mul_cu)
            p3_reg <= m3;
        if (cmd.save_s)
        begin
            sx_reg <= sat32(e0);
            sy_reg <= sat32(e1);
        end
        if (cmd.upd_sq)
        begin
            x_reg     <= sat32(nx_sq);
            y_reg     <= sat32(ny_sq);
            count_reg <= count_reg + CNT_W'(1);
        end
        if (cmd.upd_cu)
        begin
            x_reg     <= sat32(nx_cu);
            y_reg     <= sat32(ny_cu);
            count_reg <= count_reg + CNT_W'(1);
        end
        if (cmd.out_load)
        begin
            cnt_out_reg <= count_reg;
            re_out_reg  <= x_reg;
            im_out_reg  <= y_reg;
        end
    end

    assign iteration_count = cnt_out_reg;
    assign final_real      = re_out_reg;
    assign final_imag      = im_out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/jet_ctrl.sv
// ----------------------------------------------------------------------------
// jet_ctrl
// Sequencer for the escape-time loop: accepts a pixel, walks the multiply and
// update steps until escape or limit, then hands the result to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module jet_ctrl
    import jet_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_MUL_SQ,
        ST_CHECK,
        ST_MUL_CU,
        ST_UPD_CU,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Commands and next state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_pixel = 1'b1;
                    state_next     = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.init_z = 1'b1;
                state_next = ST_MUL_SQ;
            end
            ST_MUL_SQ:
            begin
                cmd.mul_sq = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.stop)
                    state_next = ST_DONE;
                else if (status.cubic)
                begin
                    cmd.save_s = 1'b1;
                    state_next = ST_MUL_CU;
                end
                else
                begin
                    cmd.upd_sq = 1'b1;
                    state_next = ST_MUL_SQ;
                end
            end
            ST_MUL_CU:
            begin
                cmd.mul_cu = 1'b1;
                state_next = ST_UPD_CU;
            end
            ST_UPD_CU:
            begin
                cmd.upd_cu = 1'b1;
                state_next = ST_MUL_SQ;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/julia_escape_time.sv
// ----------------------------------------------------------------------------
// julia_escape_time
// Julia set escape-time pixel unit in signed Q8.24 fixed point.
// ----------------------------------------------------------------------------
// Each input transaction carries one pixel; it is mapped to z = pixel*scale -
// offset per axis and iterated as z^2 + c (or z^3 + c in cubic mode) until
// |z|^2 exceeds 4.0 or max_iterations is reached. One result transaction
// returns the count and the last z, saturated to 32 bits. The unit works on
// one pixel at a time; the loop runs through a bank of four registered
// 32x32 multipliers: a quadratic iteration is a squares multiply followed by
// an escape check and update, and a cubic one adds a second multiply pass
// and its update. A finished pixel waits in its done state while an earlier
// result still holds the output register. The result sits in an output
// register, so a new pixel is taken while the previous result waits.
// Configuration is to be written only while the unit is idle; the unit
// itself does not enforce this. Writes are taken every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module julia_escape_time
    import jet_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [FX_W-1:0]   cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [PIX_W-1:0]  pixel_x,
    input  wire logic [PIX_W-1:0]  pixel_y,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [CNT_W-1:0]       iteration_count,
    output logic signed [FX_W-1:0] final_real,
    output logic signed [FX_W-1:0] final_imag
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    jet_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    jet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    jet_datapath u_dp (
        .clk             (clk),
        .cfg             (cfg),
        .cmd             (cmd),
        .status          (status),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .iteration_count (iteration_count),
        .final_real      (final_real),
        .final_imag      (final_imag)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/jet_checker.sv
// ----------------------------------------------------------------------------
// jet_checker
// Port-level checks on the escape-time unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jet_checker
    import jet_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [CNT_W-1:0]  iteration_count,
    input wire logic [FX_W-1:0]   final_real,
    input wire logic [FX_W-1:0]   final_imag
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(iteration_count)
            && $stable(final_real) && $stable(final_imag))
        else $error("result changed while stalled");

    // Only one pixel in flight: busy right after an input transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a pixel is in flight");

    // A result is only produced while a pixel was being worked on
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without work in flight");

    // Start-point mapping and the first escape test precede the result
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##2 !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind julia_escape_time jet_checker u_jet_checker (.*);

`default_nettype wire
